[rtl/json_string_unescape_utf8_core_assert.svh]
// Assertion macros used by the top level of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

[rtl/jsu_pkg.sv]
// Shared types and constants of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Default number of entries in the queue between parser and emitter.
    localparam int JSU_QUEUE_DEPTH = 4;

    // Result kinds on the output channel.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Everything one input byte asks the emitter to send.
    typedef struct packed {
        logic [3:0][7:0] data;     // UTF-8 bytes, entry 0 goes first
        logic [2:0]      n_data;   // number of data bytes, 0 to 4
        logic            has_end;  // an end word follows the data bytes
        logic            end_fail; // end word reports an error
    } job_t;

    // Queue status seen by the parser and the emitter.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

[rtl/jsu_if.sv]
// Valid/ready channel interfaces for raw string bytes and decoded results.
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_end;

    modport source (output valid, output out_byte, output out_kind, output run_end,
                    input ready);
    modport sink (input valid, input out_byte, input out_kind, input run_end,
                  output ready);
endinterface

`default_nettype wire

[rtl/jsu_front.sv]
// Parser: accepts string bytes, tracks escapes and builds UTF-8 jobs.
`default_nettype none

module jsu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    jsu_in_if.sink            body,
    input  wire logic         q_full,
    output logic              push,
    output jsu_pkg::job_t     job
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        M_TEXT = 4'd0,
        M_ESC  = 4'd1,
        M_HI0  = 4'd2,
        M_HI1  = 4'd3,
        M_HI2  = 4'd4,
        M_HI3  = 4'd5,
        M_BSL  = 4'd6,
        M_U    = 4'd7,
        M_LO0  = 4'd8,
        M_LO1  = 4'd9,
        M_LO2  = 4'd10,
        M_LO3  = 4'd11
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] high_reg, high_next;
    logic [15:0] low_reg, low_next;
    logic        failed_reg, failed_next;

    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  hex_v;
    logic        emit_cp;
    logic [20:0] cp;
    logic        emit_byte;
    logic [7:0]  plain;
    logic        accept;
    job_t        job_c;

    // Hex digit decode, both letter cases.
    always_comb
    begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            hex_v = 4'(c - "0");
        end
        else if (c >= "A" && c <= "F")
        begin
            hex_v = 4'(c - "A" + 8'd10);
        end
        else if (c >= "a" && c <= "f")
        begin
            hex_v = 4'(c - "a" + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign c      = body.in_byte;
    assign accept = body.valid && body.ready;
    assign body.ready = !q_full;

    // Escape state machine for one byte.
    always_comb
    begin
        mode_next   = mode_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        failed_next = failed_reg;
        emit_cp     = 1'b0;
        cp          = 21'd0;
        emit_byte   = 1'b0;
        plain       = c;
        if (!failed_reg)
        begin
            unique case (mode_reg)
                M_ESC:
                begin
                    mode_next = M_TEXT;
                    emit_byte = 1'b1;
                    case (c)
                        "\"":    plain = 8'h22;
                        "\\":    plain = 8'h5C;
                        "b":     plain = 8'h08;
                        "f":     plain = 8'h0C;
                        "n":     plain = 8'h0A;
                        "r":     plain = 8'h0D;
                        "t":     plain = 8'h09;
                        "u":
                        begin
                            emit_byte = 1'b0;
                            high_next = 16'd0;
                            mode_next = M_HI0;
                        end
                        default:
                        begin
                            emit_byte   = 1'b0;
                            failed_next = 1'b1;
                        end
                    endcase
                end
                M_HI0, M_HI1, M_HI2, M_HI3:
                begin
                    if (!hex_ok)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        high_next = {high_reg[11:0], hex_v};
                        if (mode_reg == M_HI3)
                        begin
                            if ((high_next & 16'hFC00) == 16'hD800)
                            begin
                                mode_next = M_BSL;
                            end
                            else
                            begin
                                emit_cp   = 1'b1;
                                cp        = {5'd0, high_next};
                                high_next = 16'd0;
                                mode_next = M_TEXT;
                            end
                        end
                        else
                        begin
                            mode_next = mode_t'(mode_reg + 4'd1);
                        end
                    end
                end
                M_BSL:
                begin
                    if (c != "\\")
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = M_U;
                    end
                end
                M_U:
                begin
                    if (c != "u")
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        low_next  = 16'd0;
                        mode_next = M_LO0;
                    end
                end
                M_LO0, M_LO1, M_LO2, M_LO3:
                begin
                    if (!hex_ok)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        low_next = {low_reg[11:0], hex_v};
                        if (mode_reg == M_LO3)
                        begin
                            emit_cp   = 1'b1;
                            cp        = 21'h10000 + {1'b0, high_reg[9:0], low_next[9:0]};
                            high_next = 16'd0;
                            low_next  = 16'd0;
                            mode_next = M_TEXT;
                        end
                        else
                        begin
                            mode_next = mode_t'(mode_reg + 4'd1);
                        end
                    end
                end
                default:
                begin
                    mode_next = M_TEXT;
                    if (c == "\\")
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        emit_byte = 1'b1;
                    end
                end
            endcase
            // Any failure drops the escape in progress.
            if (failed_next)
            begin
                mode_next = M_TEXT;
                high_next = 16'd0;
                low_next  = 16'd0;
            end
        end
    end

    // UTF-8 encoding and end word of the job.
    always_comb
    begin
        job_c = '0;
        if (emit_byte)
        begin
            job_c.data[0] = plain;
            job_c.n_data  = 3'd1;
        end
        else if (emit_cp)
        begin
            if (cp < 21'h80)
            begin
                job_c.data[0] = cp[7:0];
                job_c.n_data  = 3'd1;
            end
            else if (cp < 21'h800)
            begin
                job_c.data[0] = 8'hC0 | {3'd0, cp[10:6]};
                job_c.data[1] = 8'h80 | {2'd0, cp[5:0]};
                job_c.n_data  = 3'd2;
            end
            else if (cp < 21'h10000)
            begin
                job_c.data[0] = 8'hE0 | {4'd0, cp[15:12]};
                job_c.data[1] = 8'h80 | {2'd0, cp[11:6]};
                job_c.data[2] = 8'h80 | {2'd0, cp[5:0]};
                job_c.n_data  = 3'd3;
            end
            else
            begin
                job_c.data[0] = 8'hF0 | {5'd0, cp[20:18]};
                job_c.data[1] = 8'h80 | {2'd0, cp[17:12]};
                job_c.data[2] = 8'h80 | {2'd0, cp[11:6]};
                job_c.data[3] = 8'h80 | {2'd0, cp[5:0]};
                job_c.n_data  = 3'd4;
            end
        end
        job_c.has_end  = body.last_byte;
        job_c.end_fail = failed_next || (mode_next != M_TEXT);
    end

    assign job  = job_c;
    assign push = accept && ((job_c.n_data != 3'd0) || body.last_byte);

    // Parser state; the last byte of a string returns it to reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_TEXT;
            high_reg   <= 16'd0;
            low_reg    <= 16'd0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (body.last_byte)
            begin
                mode_reg   <= M_TEXT;
                high_reg   <= 16'd0;
                low_reg    <= 16'd0;
                failed_reg <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                high_reg   <= high_next;
                low_reg    <= low_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/jsu_queue.sv]
// Small register queue of jobs between parser and emitter.
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire jsu_pkg::job_t  wr_job,
    input  wire logic           pop,
    output jsu_pkg::job_t       head,
    output jsu_pkg::q_status_t  status
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/jsu_back.sv]
// Emitter: sends the words of each job, one per cycle while the receiver is ready, on the output channel.
`default_nettype none

module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jsu_pkg::job_t head,
    input  wire logic          head_valid,
    output logic               pop,
    jsu_out_if.source          decoded
);
    import jsu_pkg::*;

    job_t       job_reg;
    logic [2:0] idx_reg;
    logic       busy_reg;

    logic [2:0] total;
    logic       at_last;
    logic       sent;
    logic       load;

    assign total   = job_reg.n_data + {2'd0, job_reg.has_end};
    assign at_last = (idx_reg == total - 3'd1);
    assign sent    = decoded.valid && decoded.ready;
    assign load    = head_valid && (!busy_reg || (sent && at_last));
    assign pop     = load;

    // Output word selected from the held job.
    always_comb
    begin
        decoded.valid   = busy_reg;
        decoded.run_end = at_last;
        if (idx_reg < job_reg.n_data)
        begin
            decoded.out_byte = job_reg.data[idx_reg[1:0]];
            decoded.out_kind = KIND_DATA;
        end
        else
        begin
            decoded.out_byte = 8'd0;
            decoded.out_kind = job_reg.end_fail ? KIND_ERR : KIND_OK;
        end
    end

    // Held job register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= head;
        end
    end

    // Word index and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg  <= 3'd0;
            busy_reg <= 1'b1;
        end
        else if (sent)
        begin
            idx_reg  <= idx_reg + 3'd1;
            busy_reg <= !at_last;
        end
    end

endmodule

`default_nettype wire

[rtl/json_string_unescape_utf8_core.sv]
// Top level of the JSON string unescaper with UTF-8 output.
//
// Channel body carries the bytes of a JSON string body (no quotes), with
// last_byte set on the final byte. Channel decoded carries result words:
// UTF-8 data bytes (kind 0), then after the final byte one end word that
// reports ok (kind 1) or error (kind 2). run_end marks the last word that a
// given input byte caused; bytes such as a backslash or hex digits cause none.
// Both channels move a word on a clock edge where valid and ready are high.
// Throughput: one input byte per cycle while each byte causes at most one
// word; a byte that causes more words holds the emitter, since it sends
// one word per cycle. The job queue (QUEUE_DEPTH entries) absorbs such
// bursts; body.ready drops only when the queue is full.
// The first word of a byte passes the queue and then the emitter's held
// job register before it is valid.
// When the receiver stalls, the current word holds and the queue fills, then
// the input stalls. Reset empties the queue and returns the parser to plain
// text with no error; no clearing pass is needed.
`default_nettype none

module json_string_unescape_utf8_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    jsu_in_if.sink    body,
    jsu_out_if.source decoded
);
    import jsu_pkg::*;

`include "json_string_unescape_utf8_core_assert.svh"

    logic      q_push;
    logic      q_pop;
    job_t      q_wr_job;
    job_t      q_head;
    q_status_t q_status;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body),
        .q_full (q_status.full),
        .push   (q_push),
        .job    (q_wr_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (q_wr_job),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (!q_status.empty),
        .pop        (q_pop),
        .decoded    (decoded)
    );

    // An end word is always the last word of its input byte.
    `JSU_ASSERT_SAME(a_end_is_run_end, clk, rst_n,
        decoded.valid && decoded.out_kind != KIND_DATA, decoded.run_end)

    // The emitter never takes a job from an empty queue.
    `JSU_ASSERT_SAME(a_no_pop_empty, clk, rst_n, q_status.empty, !q_pop)

    // A job enters the queue only with an accepted byte.
    `JSU_ASSERT_SAME(a_push_on_accept, clk, rst_n, q_push, body.valid && body.ready)

    // A final byte always leaves a job behind it in the queue.
    `JSU_ASSERT_NEXT(a_last_queued, clk, rst_n,
        body.valid && body.ready && body.last_byte, !q_status.empty || decoded.valid)

endmodule

`default_nettype wire
